// ----- hdl/cbtp_pkg.sv -----
// Shared types, constants and helper functions of the color bar test pattern block.
package cbtp_pkg;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;

    localparam int CFG_W   = 12;
    localparam int COORD_W = 11;
    localparam int FRAME_W = 32;
    localparam int COLOR_W = 16;
    localparam int STAT_W  = 2;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    // Only the low 28 bits of the frame number survive the wrapped multiply by 16.
    localparam int FR_W      = 28;
    // Remainder of the motion phase, below twice the travel in 16-pixel units.
    localparam int REM_W     = 9;
    localparam int MOD_STAGES = 4;
    localparam int MOD_STEPS  = FR_W / MOD_STAGES;
    localparam int STAGES     = MOD_STAGES + 2;

    localparam logic [CFG_W-1:0] SQ_SIZE    = 12'd40;
    localparam logic [CFG_W-1:0] BAND_ROWS  = 12'd16;
    localparam logic [CFG_W-1:0] MIN_HEIGHT = 12'd56;
    localparam logic [CFG_W-1:0] RST_WIDTH  = 12'd640;
    localparam logic [CFG_W-1:0] RST_HEIGHT = 12'd360;

    localparam logic [COLOR_W-1:0] COLOR_WHITE = 16'hFFFF;
    localparam logic [COLOR_W-1:0] COLOR_BLACK = 16'h0000;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_GEOM  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [FR_W-1:0]    fr;
        logic [4:0]         grey;
        logic [REM_W-1:0]   rem;
        logic [STAT_W-1:0]  status;
        logic [2:0]         bar;
        logic               band;
        logic               vert;
        logic [COLOR_W-1:0] color;
    } t_pix;

    function automatic logic [COLOR_W-1:0] bar_color(input logic [2:0] idx);
        logic [COLOR_W-1:0] c;
        case (idx)
            3'd0:    c = 16'hFFFF;
            3'd1:    c = 16'hFFE0;
            3'd2:    c = 16'h07FF;
            3'd3:    c = 16'h07E0;
            3'd4:    c = 16'hF81F;
            3'd5:    c = 16'hF800;
            3'd6:    c = 16'h001F;
            default: c = 16'h0000;
        endcase
        return c;
    endfunction

    // One restoring step of the remainder: shift in a bit, subtract the divisor if it fits.
    function automatic logic [REM_W-1:0] mod_step(input logic [REM_W-1:0] r, input logic b,
                                                  input logic [REM_W-1:0] d);
        logic [REM_W:0] t;
        t = {r, b};
        if (t >= {1'b0, d}) begin
            t = t - {1'b0, d};
        end
        return t[REM_W-1:0];
    endfunction

endpackage

// ----- hdl/cbtp_if.sv -----
// Valid/ready stream interfaces for pixel requests and pixel results.
interface cbtp_in_if;
    import cbtp_pkg::*;
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [FRAME_W-1:0] frame_number;
    modport source (output valid, pixel_x, pixel_y, frame_number, input ready);
    modport sink   (input valid, pixel_x, pixel_y, frame_number, output ready);
endinterface

interface cbtp_out_if;
    import cbtp_pkg::*;
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] pixel_color;
    logic [STAT_W-1:0]  status;
    modport source (output valid, pixel_color, status, input ready);
    modport sink   (input valid, pixel_color, status, output ready);
endinterface

// ----- hdl/color_bar_test_pattern.sv -----
// Top level of the color bar test pattern generator: pixel pipeline and APB registers.
// Takes one pixel request per clock when not stalled and returns its RGB565 color in a
// six-stage pipeline: an input register, four stages that each resolve seven bits of the
// square's motion phase (frame number modulo twice the travel, computed one bit per step),
// and a final stage that places the square and selects the color. Each stage stalls only
// when the stage after it is full and not moving, so bubbles are squeezed out under
// back-pressure. Write frame_width and frame_height only while no transaction is in flight.
module color_bar_test_pattern #(
    parameter int MAX_WIDTH  = cbtp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cbtp_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    cbtp_in_if.sink                       i_pix,
    cbtp_out_if.source                    o_pix,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cbtp_pkg::ADDR_W-1:0]   paddr,
    input  logic [cbtp_pkg::DATA_W-1:0]   pwdata,
    output logic [cbtp_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import cbtp_pkg::*;

    logic [CFG_W-1:0] r_width;
    logic [CFG_W-1:0] r_height;

    t_pix        r_stg [STAGES];
    t_pix        n_stg [STAGES];
    logic        r_vld [STAGES];
    logic        w_adv [STAGES];

    logic [7:0]       w_m;
    logic [REM_W-1:0] w_div;
    logic             w_geom_bad;
    logic [CFG_W-1:0] w_sy;
    logic [8:0]       w_bw;

    // ---------------- Configuration registers ----------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_HEIGHT) ? DATA_W'(r_height) : DATA_W'(r_width);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_WIDTH) begin
                r_width <= pwdata[CFG_W-1:0];
            end else begin
                r_height <= pwdata[CFG_W-1:0];
            end
        end
    end

    // ---------------- Values derived from the static geometry ----------------
    always_comb begin
        logic [CFG_W-1:0] wm40;
        wm40 = r_width - SQ_SIZE;
        // Travel in 16-pixel units; zero when the frame is too narrow to move the square.
        w_m   = (r_width >= SQ_SIZE + BAND_ROWS) ? wm40[CFG_W-1:4] : 8'd0;
        w_div = {w_m, 1'b0};
        w_geom_bad = (r_width == '0) || (r_width[2:0] != 3'd0) ||
                     (32'(r_width) > 32'(MAX_WIDTH)) || (r_height < MIN_HEIGHT) ||
                     (32'(r_height) > 32'(MAX_HEIGHT));
        w_sy = (r_height - MIN_HEIGHT) >> 1;
        w_bw = r_width[CFG_W-1:3];
    end

    // ---------------- Stage flow control ----------------
    always_comb begin
        w_adv[STAGES-1] = !r_vld[STAGES-1] || o_pix.ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    assign i_pix.ready = w_adv[0];

    // ---------------- Stage data ----------------
    always_comb begin
        t_pix              s;
        logic [REM_W-1:0]  r;
        logic [2:0]        cnt;
        logic [CFG_W-1:0]  thr;
        logic [REM_W-1:0]  units;
        logic [CFG_W:0]    sx;
        logic              in_h;

        // Input capture.
        s        = r_stg[0];
        s.x      = i_pix.pixel_x;
        s.y      = i_pix.pixel_y;
        s.fr     = i_pix.frame_number[FR_W-1:0];
        s.grey   = i_pix.frame_number[4:0];
        s.rem    = '0;
        s.status = ST_OK;
        s.bar    = '0;
        s.band   = 1'b0;
        s.vert   = 1'b0;
        s.color  = COLOR_BLACK;
        n_stg[0] = s;

        // Remainder stages; the first one also classifies the pixel.
        for (int k = 1; k <= MOD_STAGES; k++) begin
            s = r_stg[k-1];
            if (k == 1) begin
                if (w_geom_bad) begin
                    s.status = ST_GEOM;
                end else if (({1'b0, s.x} >= r_width) || ({1'b0, s.y} >= r_height)) begin
                    s.status = ST_RANGE;
                end else begin
                    s.status = ST_OK;
                end
                s.band = {1'b0, s.y} >= (r_height - BAND_ROWS);
                s.vert = ({1'b0, s.y} >= w_sy) && ({1'b0, s.y} < (w_sy + SQ_SIZE));
                // Bar index is the number of bar boundaries at or left of the pixel.
                cnt = '0;
                for (int b = 1; b < 8; b++) begin
                    thr = CFG_W'(b) * {3'b000, w_bw};
                    cnt = cnt + 3'({1'b0, s.x} >= thr);
                end
                s.bar = cnt;
                r = '0;
            end else begin
                r = s.rem;
            end
            for (int j = 0; j < MOD_STEPS; j++) begin
                r = mod_step(r, s.fr[FR_W - MOD_STEPS * k + MOD_STEPS - 1 - j], w_div);
            end
            s.rem    = r;
            n_stg[k] = s;
        end

        // Final stage: fold the phase into a triangle wave and pick the color.
        s = r_stg[STAGES-2];
        if (w_m == 8'd0) begin
            units = '0;
        end else if (s.rem < {1'b0, w_m}) begin
            units = s.rem;
        end else begin
            units = w_div - s.rem;
        end
        sx   = {units, 4'b0000};
        in_h = ({2'b00, s.x} >= sx) && ({2'b00, s.x} < (sx + {1'b0, SQ_SIZE}));
        if (s.status != ST_OK) begin
            s.color = COLOR_BLACK;
        end else if (s.band) begin
            s.color = {s.grey, s.grey, 1'b0, s.grey};
        end else if (s.vert && in_h) begin
            s.color = COLOR_WHITE;
        end else begin
            s.color = bar_color(s.bar);
        end
        n_stg[STAGES-1] = s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < STAGES; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_pix.valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < STAGES; k++) begin
            if (w_adv[k]) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    assign o_pix.valid       = r_vld[STAGES-1];
    assign o_pix.pixel_color = r_stg[STAGES-1].color;
    assign o_pix.status      = r_stg[STAGES-1].status;

    // ---------------- Assertions ----------------
    a_err_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix.valid && (o_pix.status != ST_OK)) |-> (o_pix.pixel_color == COLOR_BLACK))
        else $error("error status with a nonzero pixel color");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix.valid |-> ((o_pix.status == ST_OK) || (o_pix.status == ST_GEOM) ||
                         (o_pix.status == ST_RANGE)))
        else $error("undefined status code on the output");

    a_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready) |=> r_vld[0])
        else $error("accepted transaction did not enter the pipeline");

    a_geom_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[0] && w_adv[1] && w_geom_bad) |=> (r_stg[1].status == ST_GEOM))
        else $error("bad geometry not flagged ahead of the range check");

endmodule

// ----- tb/tb_color_bar_test_pattern.sv -----
// Self-checking testbench for the color bar test pattern generator.
module tb_color_bar_test_pattern;
    timeunit 1ns;
    timeprecision 1ps;
    import cbtp_pkg::*;

    localparam int MAX_W          = DEF_MAX_WIDTH;
    localparam int MAX_H          = DEF_MAX_HEIGHT;
    localparam int PIPE_LATENCY   = 8;
    localparam int HOLDOFF_CYCLES = 80;
    localparam int STALL_LIMIT    = 2000;

    // Bar colors, left to right: white, yellow, cyan, green, magenta, red, blue, black.
    localparam logic [7:0][COLOR_W-1:0] BAR_RGB = {
        16'h0000, 16'h001F, 16'hF800, 16'hF81F, 16'h07E0, 16'h07FF, 16'hFFE0, 16'hFFFF
    };

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [FRAME_W-1:0] frame;
    } t_pix_req;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [STAT_W-1:0]  status;
    } t_pix_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    cbtp_in_if  pix_in();
    cbtp_out_if pix_out();

    color_bar_test_pattern DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_in),
        .o_pix   (pix_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [CFG_W-1:0] cfg_width  = RST_WIDTH;
    logic [CFG_W-1:0] cfg_height = RST_HEIGHT;

    t_pix_req    req_queue[$];
    t_pix_result color_expect[$];

    logic req_accepted  = 1'b0;
    bit   no_idle       = 1'b0;
    int   holdoff_asked = 0;
    int   holdoff_done  = 0;
    int   holdoff_left  = 0;
    int   quiet_cycles  = 0;
    int   n_errors      = 0;
    int   n_checked     = 0;
    int   n_in_frame    = 0;
    int   n_bad_geom    = 0;
    int   n_outside     = 0;
    int   n_geometries  = 1;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Left column of the moving square: a triangle wave over the travel range.
    function automatic logic [31:0] square_origin(input logic [CFG_W-1:0] w,
                                                 input logic [FRAME_W-1:0] frame);
        logic [31:0] travel;
        logic [31:0] period;
        logic [31:0] phase;
        if (32'(w) < 32'd56) begin
            return 32'd0;
        end
        travel = ((32'(w) - 32'd40) >> 4) << 4;
        period = travel << 1;
        phase  = (frame << 4) % period;
        return (phase < travel) ? phase : period - phase;
    endfunction

    function automatic t_pix_result predict_pixel(input t_pix_req req,
                                                  input logic [CFG_W-1:0] w,
                                                  input logic [CFG_W-1:0] h);
        t_pix_result res;
        logic [31:0] band_top;
        logic [31:0] sx;
        logic [31:0] sy;
        logic [7:0]  level;
        logic [2:0]  bar;
        res = '0;
        if (w == 0 || w[2:0] != 3'd0 || 32'(w) > MAX_W || h < MIN_HEIGHT || 32'(h) > MAX_H) begin
            res.status = ST_GEOM;
        end else if (12'(req.x) >= w || 12'(req.y) >= h) begin
            res.status = ST_RANGE;
        end else begin
            res.status = ST_OK;
            band_top   = 32'(h) - 32'd16;
            if (32'(req.y) >= band_top) begin
                level     = {req.frame[4:0], 3'b000};
                res.color = {level[7:3], level[7:2], level[7:3]};
            end else begin
                bar       = 3'(32'(req.x) / (32'(w) >> 3));
                res.color = BAR_RGB[bar];
                sx = square_origin(w, req.frame);
                sy = (band_top - 32'd40) >> 1;
                if (32'(req.x) >= sx && 32'(req.x) < sx + 32'd40 &&
                    32'(req.y) >= sy && 32'(req.y) < sy + 32'd40) begin
                    res.color = COLOR_WHITE;
                end
            end
        end
        return res;
    endfunction

    // Request driver: a new pixel is offered only when the slot is free.
    always @(negedge i_clk) begin
        t_pix_req nxt;
        if (!i_rst_n) begin
            pix_in.valid <= 1'b0;
        end else if (!pix_in.valid || req_accepted) begin
            if (req_queue.size() != 0 && (no_idle || $urandom_range(99) >= 14)) begin
                nxt = req_queue.pop_front();
                pix_in.valid        <= 1'b1;
                pix_in.pixel_x      <= nxt.x;
                pix_in.pixel_y      <= nxt.y;
                pix_in.frame_number <= nxt.frame;
            end else begin
                pix_in.valid <= 1'b0;
            end
        end
    end

    // Result sink: random stalls plus an occasional long hold-off.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pix_out.ready <= 1'b0;
        end else if (holdoff_left != 0) begin
            pix_out.ready <= 1'b0;
            holdoff_left  <= holdoff_left - 1;
        end else if (holdoff_done != holdoff_asked) begin
            pix_out.ready <= 1'b0;
            holdoff_left  <= HOLDOFF_CYCLES;
            holdoff_done  <= holdoff_asked;
        end else begin
            pix_out.ready <= no_idle || ($urandom_range(99) >= 14);
        end
    end

    // Monitor: predicts each accepted request and checks each returned pixel.
    always @(posedge i_clk) begin
        t_pix_result pred;
        t_pix_result want;
        t_pix_req    req;
        req_accepted <= i_rst_n && pix_in.valid && pix_in.ready;
        if (i_rst_n && pix_in.valid && pix_in.ready) begin
            req.x     = pix_in.pixel_x;
            req.y     = pix_in.pixel_y;
            req.frame = pix_in.frame_number;
            pred = predict_pixel(req, cfg_width, cfg_height);
            color_expect.push_back(pred);
            case (pred.status)
                ST_OK:    n_in_frame++;
                ST_GEOM:  n_bad_geom++;
                default:  n_outside++;
            endcase
        end
        if (i_rst_n && pix_out.valid && pix_out.ready) begin
            if (color_expect.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual color %h status %0d",
                         $time, pix_out.pixel_color, pix_out.status);
                n_errors++;
            end else begin
                want = color_expect.pop_front();
                n_checked++;
                if (pix_out.pixel_color !== want.color) begin
                    $display("%0t: pixel_color mismatch, expected %h, actual %h",
                             $time, want.color, pix_out.pixel_color);
                    n_errors++;
                end
                if (pix_out.status !== want.status) begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, pix_out.status);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                         $time, STALL_LIMIT, color_expect.size());
                $display("tb_color_bar_test_pattern NOT OK");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
        logic [DATA_W-1:0] data;
        // Upper bits carry noise; only the low twelve bits are stored.
        data = ($urandom() & 32'hFFFF_F000) | 32'(value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_WIDTH) begin
            cfg_width = value;
        end else begin
            cfg_height = value;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Checked at the rising edge, where the request side is stable.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (req_queue.size() != 0 || pix_in.valid || color_expect.size() != 0);
    endtask

    task automatic queue_pixel(input int x, input int y, input logic [FRAME_W-1:0] frame);
        t_pix_req req;
        req.x     = COORD_W'(x);
        req.y     = COORD_W'(y);
        req.frame = frame;
        req_queue.push_back(req);
    endtask

    // Random requests biased toward the square, the grey band and the frame edges.
    task automatic queue_random(input int count);
        t_pix_req    req;
        int          mode;
        logic [31:0] lim_x;
        logic [31:0] lim_y;
        logic [31:0] sx;
        logic [31:0] sy;
        for (int i = 0; i < count; i++) begin
            mode  = $urandom_range(9);
            lim_x = (cfg_width == 0 || 32'(cfg_width) > MAX_W) ? 32'd2047 : 32'(cfg_width) - 1;
            lim_y = (cfg_height == 0 || 32'(cfg_height) > MAX_H) ? 32'd2047 : 32'(cfg_height) - 1;
            req.frame = $urandom_range(1) ? $urandom() : $urandom_range(200);
            sx = square_origin(cfg_width, req.frame);
            sy = (32'(cfg_height) - 32'd56) >> 1;
            req.x = COORD_W'($urandom_range(lim_x));
            req.y = COORD_W'($urandom_range(lim_y));
            case (mode)
                0: begin
                    req.x = COORD_W'($urandom());
                    req.y = COORD_W'($urandom());
                end
                1, 2, 3: begin
                    req.x = COORD_W'(sx - 1 + $urandom_range(41));
                    req.y = COORD_W'(sy - 1 + $urandom_range(41));
                end
                4, 5: req.y = COORD_W'(lim_y - $urandom_range(16));
                6:    req.x = COORD_W'(lim_x + $urandom_range(2));
                7:    req.y = COORD_W'(lim_y + $urandom_range(2));
                default: ;
            endcase
            req_queue.push_back(req);
        end
    endtask

    task automatic run_geometry(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                                input int count, input bit hold, input bit mid_pause);
        repeat (PIPE_LATENCY) @(negedge i_clk);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        n_geometries++;
        if (hold) begin
            holdoff_asked++;
        end
        queue_random(count / 2);
        if (mid_pause) begin
            wait_drained();
        end
        queue_random(count - count / 2);
        wait_drained();
    endtask

    initial begin
        i_rst_n             = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        pix_in.valid        = 1'b0;
        pix_in.pixel_x      = '0;
        pix_in.pixel_y      = '0;
        pix_in.frame_number = '0;
        pix_out.ready       = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset geometry 640x360: bars 80 wide, band from row 344, square rows 152..191.
        queue_pixel(0, 0, 0);
        queue_pixel(79, 10, 0);
        for (int k = 1; k < 8; k++) begin
            queue_pixel(80 * k, 10, 0);
        end
        queue_pixel(639, 343, 0);
        queue_pixel(0, 344, 0);
        queue_pixel(639, 359, 31);
        queue_pixel(100, 359, 32'hFFFF_FFFF);
        // Square edges with the square at column 160.
        queue_pixel(160, 152, 10);
        queue_pixel(199, 191, 10);
        queue_pixel(200, 152, 10);
        queue_pixel(159, 152, 10);
        queue_pixel(160, 192, 10);
        // Turning point of the triangle wave and the wrap back to column 0.
        queue_pixel(631, 170, 37);
        queue_pixel(632, 170, 37);
        queue_pixel(39, 170, 74);
        queue_pixel(640, 0, 0);
        queue_pixel(0, 360, 0);
        queue_pixel(2047, 2047, 32'hFFFF_FFFF);
        wait_drained();

        run_geometry(12'd8,    12'd56,   60, 1'b0, 1'b0);
        run_geometry(12'd2048, 12'd2048, 70, 1'b1, 1'b0);
        run_geometry(12'd56,   12'd100,  50, 1'b0, 1'b0);
        run_geometry(12'd64,   12'd57,   60, 1'b0, 1'b1);
        run_geometry(12'd2040, 12'd56,   50, 1'b0, 1'b0);
        no_idle = 1'b1;
        run_geometry(12'd1280, 12'd720,  60, 1'b0, 1'b0);
        no_idle = 1'b0;
        run_geometry(12'd0,    12'd360,  12, 1'b0, 1'b0);
        run_geometry(12'd644,  12'd360,  12, 1'b0, 1'b0);
        run_geometry(12'd2056, 12'd360,  12, 1'b0, 1'b0);
        run_geometry(12'd640,  12'd55,   12, 1'b0, 1'b0);
        run_geometry(12'd640,  12'd2049, 12, 1'b0, 1'b0);
        run_geometry(12'd4095, 12'd4095, 12, 1'b0, 1'b0);

        repeat (PIPE_LATENCY + 2) @(posedge i_clk);
        $display("Checked %0d pixels over %0d frame geometries: %0d in frame, %0d with bad",
                 n_checked, n_geometries, n_in_frame, n_bad_geom);
        $display("geometry, %0d outside the frame, with random stalls and a long output hold-off.",
                 n_outside);
        if (n_errors == 0 && color_expect.size() == 0) begin
            $display("tb_color_bar_test_pattern OK");
        end else begin
            $display("tb_color_bar_test_pattern NOT OK");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/cbtp_pkg.sv
hdl/cbtp_if.sv
hdl/color_bar_test_pattern.sv
tb/tb_color_bar_test_pattern.sv
